FILE: design/sbcc_pkg.sv
// ----------------------------------------------------------------------------
// sbcc_pkg
// Shared types and constants for the sphere/box collision check: box corner
// layout, controller state codes, and the command/status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sbcc_pkg;

	localparam int unsigned COORD_W  = 16;  // Q8.8 signed position
	localparam int unsigned SIZE_W   = 16;  // Q8.8 unsigned size and radius
	localparam int unsigned CORNER_W = 17;  // Q9.8 signed corner
	localparam int unsigned DIST_W   = 17;  // per-axis distance magnitude
	localparam int unsigned SQ_W     = 2 * DIST_W;
	localparam int unsigned SUM_W    = SQ_W + 2;
	localparam int unsigned R2_W     = 2 * SIZE_W;
	localparam int unsigned AXES     = 3;
	localparam int unsigned IDX_W    = 6;
	localparam int unsigned CNT_CFG_W = 7;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic signed [CORNER_W-1:0] corner_coord_t;

	typedef struct packed {
		corner_coord_t x;
		corner_coord_t y;
		corner_coord_t z;
	} corner_t;

	typedef struct packed {
		corner_t lo;
		corner_t hi;
	} box_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	typedef struct packed {
		logic capture;  // latch query centre and radius squared, clear hit
		logic wr_en;    // write box entry from the input item
		logic rd_en;    // read one box into the test pipeline
	} dp_cmd_t;

	typedef struct packed {
		logic busy;     // boxes still in the test pipeline
		logic hit;      // some tested box met the sphere
	} dp_status_t;

	// Corner from centre and full size: centre -/+ size/2, truncated.
	function automatic corner_coord_t corner_of(input logic signed [COORD_W-1:0] pos,
			input logic [SIZE_W-1:0] size, input logic upper);
		logic signed [CORNER_W-1:0] p;
		logic signed [CORNER_W-1:0] half;
		p = CORNER_W'(pos);
		half = $signed({2'b00, size[SIZE_W-1:1]});
		return upper ? (p + half) : (p - half);
	endfunction

endpackage

FILE: design/sphere_box_collision_check.sv
// ----------------------------------------------------------------------------
// sphere_box_collision_check
// Sphere against axis-aligned box test over a table of boxes.
//
// Input channel (in_valid / in_stall): operation 0 writes box entry_index
// from centre pos_* and full size size_*; operation 1 queries a sphere at
// pos_* with radius. Output channel (out_valid / out_stall) returns one hit
// bit per item: 0 for writes, 1 when any of the first active_boxes entries
// lies closer than radius to the centre. cfg_wr_en / cfg_wr_data set
// active_boxes; write it only while the block is idle.
//
// One item is in work at a time. A write goes from ST_DONE into the output
// register; a query reads n = min(active_boxes, MAX_BOXES) boxes through the
// single table read port, feeding a 4-stage test pipeline one box per cycle,
// waits in ST_DRAIN for the pipeline to empty and then loads the result. The
// next item is taken once the result enters the output register, even if
// that result is still waiting.
//
// Reset clears control state and active_boxes; the box table is not cleared
// and entries must be written before a query covers them. While out_stall is
// high a valid result holds and a finished item waits until it is taken.
// ----------------------------------------------------------------------------
module sphere_box_collision_check
	import sbcc_pkg::*;
#(
	parameter int unsigned MAX_BOXES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       operation,
	input  logic [IDX_W-1:0]           entry_index,
	input  logic signed [COORD_W-1:0]  pos_x,
	input  logic signed [COORD_W-1:0]  pos_y,
	input  logic signed [COORD_W-1:0]  pos_z,
	input  logic [SIZE_W-1:0]          size_x,
	input  logic [SIZE_W-1:0]          size_y,
	input  logic [SIZE_W-1:0]          size_z,
	input  logic [SIZE_W-1:0]          radius,
	input  logic                       cfg_wr_en,
	input  logic [CNT_CFG_W-1:0]       cfg_wr_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hit
);

	localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

	dp_cmd_t       cmd;
	dp_status_t    status;
	logic [AW-1:0] rd_addr;

	sbcc_ctrl #(
		.MAX_BOXES (MAX_BOXES),
		.AW        (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.entry_index (entry_index),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.status      (status)
	);

	sbcc_datapath #(
		.MAX_BOXES (MAX_BOXES),
		.AW        (AW)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.entry_index (entry_index),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.size_x      (size_x),
		.size_y      (size_y),
		.size_z      (size_z),
		.radius      (radius),
		.status      (status)
	);

endmodule

FILE: design/sbcc_ctrl.sv
// ----------------------------------------------------------------------------
// sbcc_ctrl
// Controller: takes items, sweeps the active boxes one per cycle, waits for
// the test pipeline to empty and hands the result to the output register.
// ----------------------------------------------------------------------------
module sbcc_ctrl
	import sbcc_pkg::*;
#(
	parameter int unsigned MAX_BOXES = 64,
	parameter int unsigned AW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 operation,
	input  logic [IDX_W-1:0]     entry_index,
	input  logic                 cfg_wr_en,
	input  logic [CNT_CFG_W-1:0] cfg_wr_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 hit,
	output dp_cmd_t              cmd,
	output logic [AW-1:0]        rd_addr,
	input  dp_status_t           status
);

	localparam int unsigned CW = $clog2(MAX_BOXES + 1);

	state_t               state_q;
	logic [CNT_CFG_W-1:0] active_boxes_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        limit_q;
	logic                 is_query_q;
	logic                 out_valid_q;
	logic                 hit_q;
	logic                 accept;
	logic                 load_out;
	logic [CW-1:0]        limit_d;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign rd_addr = cnt_q[AW-1:0];

	// Clip the active count to the table depth.
	always_comb begin
		if (32'(active_boxes_q) >= MAX_BOXES) begin
			limit_d = CW'(MAX_BOXES);
		end else begin
			limit_d = CW'(active_boxes_q);
		end
	end

	always_comb begin
		cmd.capture = accept && (operation == OP_QUERY);
		cmd.wr_en   = accept && (operation == OP_WRITE) && (32'(entry_index) < MAX_BOXES);
		cmd.rd_en   = (state_q == ST_SCAN) && (cnt_q != limit_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_boxes_q <= '0;
		end else if (cfg_wr_en) begin
			active_boxes_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			limit_q    <= '0;
			is_query_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						is_query_q <= (operation == OP_QUERY);
						cnt_q      <= '0;
						limit_q    <= limit_d;
						state_q    <= (operation == OP_QUERY) ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (cnt_q == limit_q) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!status.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: hold while stalled, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			hit_q <= is_query_q && status.hit;
		end
	end

endmodule

FILE: design/sbcc_datapath.sv
// ----------------------------------------------------------------------------
// sbcc_datapath
// Box table and test pipeline: read, clamp distance, square, sum and compare
// against radius squared, one box per cycle.
// ----------------------------------------------------------------------------
module sbcc_datapath
	import sbcc_pkg::*;
#(
	parameter int unsigned MAX_BOXES = 64,
	parameter int unsigned AW = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	input  logic [AW-1:0]              rd_addr,
	input  logic [IDX_W-1:0]           entry_index,
	input  logic signed [COORD_W-1:0]  pos_x,
	input  logic signed [COORD_W-1:0]  pos_y,
	input  logic signed [COORD_W-1:0]  pos_z,
	input  logic [SIZE_W-1:0]          size_x,
	input  logic [SIZE_W-1:0]          size_y,
	input  logic [SIZE_W-1:0]          size_z,
	input  logic [SIZE_W-1:0]          radius,
	output dp_status_t                 status
);

	box_entry_t box_mem [MAX_BOXES];
	box_entry_t wr_entry;

	logic signed [COORD_W-1:0] pos_q [AXES];
	logic [R2_W-1:0]           r2_q;
	logic                      hit_q;

	box_entry_t      rd_data_s1;
	logic            v_s1;
	logic [DIST_W-1:0] dist_s2 [AXES];
	logic            v_s2;
	logic [SQ_W-1:0] sq_s3 [AXES];
	logic            v_s3;

	corner_coord_t     lo_c [AXES];
	corner_coord_t     hi_c [AXES];
	logic [DIST_W-1:0] dist_d [AXES];
	logic [SUM_W-1:0]  sum_d;

	always_comb begin
		wr_entry.lo.x = corner_of(pos_x, size_x, 1'b0);
		wr_entry.lo.y = corner_of(pos_y, size_y, 1'b0);
		wr_entry.lo.z = corner_of(pos_z, size_z, 1'b0);
		wr_entry.hi.x = corner_of(pos_x, size_x, 1'b1);
		wr_entry.hi.y = corner_of(pos_y, size_y, 1'b1);
		wr_entry.hi.z = corner_of(pos_z, size_z, 1'b1);
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			box_mem[AW'(entry_index)] <= wr_entry;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= box_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_q[0] <= pos_x;
			pos_q[1] <= pos_y;
			pos_q[2] <= pos_z;
			r2_q     <= radius * radius;
		end
	end

	// Clamp distance per axis: zero inside the slab.
	always_comb begin
		lo_c[0] = rd_data_s1.lo.x;
		lo_c[1] = rd_data_s1.lo.y;
		lo_c[2] = rd_data_s1.lo.z;
		hi_c[0] = rd_data_s1.hi.x;
		hi_c[1] = rd_data_s1.hi.y;
		hi_c[2] = rd_data_s1.hi.z;
		for (int a = 0; a < AXES; a++) begin
			if (CORNER_W'(pos_q[a]) < lo_c[a]) begin
				dist_d[a] = DIST_W'((CORNER_W+1)'(lo_c[a]) - (CORNER_W+1)'(pos_q[a]));
			end else if (CORNER_W'(pos_q[a]) > hi_c[a]) begin
				dist_d[a] = DIST_W'((CORNER_W+1)'(pos_q[a]) - (CORNER_W+1)'(hi_c[a]));
			end else begin
				dist_d[a] = '0;
			end
		end
	end

	assign sum_d = SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);

	always_ff @(posedge clk) begin
		for (int a = 0; a < AXES; a++) begin
			dist_s2[a] <= dist_d[a];
			sq_s3[a]   <= dist_s2[a] * dist_s2[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.capture) begin
				hit_q <= 1'b0;
			end else if (v_s3 && (sum_d < SUM_W'(r2_q))) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign status.busy = v_s1 || v_s2 || v_s3;
	assign status.hit  = hit_q;

endmodule
